### rtl/core/insl_pkg.sv
// insl_pkg: shared constants, types and helpers for the image stream loader core
// no dependencies; used by ines_image_stream_loader_core
`default_nettype none

package insl_pkg;

    localparam int PRG_BANK_BYTES = 16384;
    localparam int CHR_BANK_BYTES = 8192;

    localparam int HEADER_LEN  = 16;
    localparam int TRAINER_LEN = 512;
    localparam int MAGIC_LEN   = 4;

    localparam int POS_W    = 23;
    localparam int OFFSET_W = 22;
    localparam int BYTE_W   = 8;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // header byte positions
    localparam logic [POS_W-1:0] POS_PRG_COUNT = POS_W'(4);
    localparam logic [POS_W-1:0] POS_CHR_COUNT = POS_W'(5);
    localparam logic [POS_W-1:0] POS_FLAGS6    = POS_W'(6);
    localparam logic [POS_W-1:0] POS_FLAGS7    = POS_W'(7);

    // flags six bits
    localparam int FLAG6_VERTICAL    = 0;
    localparam int FLAG6_TRAINER     = 2;
    localparam int FLAG6_FOUR_SCREEN = 3;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_MAGIC = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } load_status_t;

    typedef enum logic [1:0] {
        MIRROR_HORIZONTAL  = 2'd0,
        MIRROR_VERTICAL    = 2'd1,
        MIRROR_FOUR_SCREEN = 2'd2
    } mirroring_t;

    typedef struct packed {
        logic                prg_write;
        logic                chr_write;
        logic [OFFSET_W-1:0] rom_offset;
        logic [BYTE_W-1:0]   rom_byte;
        logic                image_done;
        load_status_t        load_status;
        logic [BYTE_W-1:0]   mapper_number;
        mirroring_t          mirroring;
        logic [BYTE_W-1:0]   prg_bank_count;
        logic [BYTE_W-1:0]   chr_bank_count;
        logic                chr_is_ram;
    } result_t;

    function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = 8'h4e;
            2'd1:    b = 8'h45;
            2'd2:    b = 8'h53;
            2'd3:    b = 8'h1a;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ines_image_stream_loader_core.sv
// ines_image_stream_loader_core: parses a ROM image header and streams payload writes
// depends on insl_pkg for constants, status codes and the result struct
//
// usage:
//   input channel (s_valid/s_ready) carries one image byte per beat, with
//   s_end_of_file high on the final byte of an image. the next beat after
//   that starts a new image.
//   result channel (m_valid/m_ready) carries exactly one result beat per
//   input beat: a prg or chr write with its offset, or nothing, and on the
//   final byte the load status and, with a full header and good magic, the header fields.
//   the result of a byte is registered and appears in the cycle after its input beat is accepted.
//   throughput: one byte per cycle while results are taken; all per-byte work is
//   position compares, constant multiplies and adds before the output register.
//   stall: while a result waits and m_ready is low, s_ready drops; when the
//   result is taken in the same cycle a new byte is accepted.
//   reset: synchronous, active low; position clears, magic flag sets,
//   header registers clear, and the output register empties.
`default_nettype none

module ines_image_stream_loader_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [insl_pkg::BYTE_W-1:0]   s_file_byte,
    input  wire logic                          s_end_of_file,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_prg_write,
    output logic                               m_chr_write,
    output logic [insl_pkg::OFFSET_W-1:0]      m_rom_offset,
    output logic [insl_pkg::BYTE_W-1:0]        m_rom_byte,
    output logic                               m_image_done,
    output logic [1:0]                         m_load_status,
    output logic [insl_pkg::BYTE_W-1:0]        m_mapper_number,
    output logic [1:0]                         m_mirroring,
    output logic [insl_pkg::BYTE_W-1:0]        m_prg_bank_count,
    output logic [insl_pkg::BYTE_W-1:0]        m_chr_bank_count,
    output logic                               m_chr_is_ram
);

    logic [insl_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                        magic_good_reg, magic_good_next;
    logic [insl_pkg::BYTE_W-1:0] prg_count_reg, prg_count_next;
    logic [insl_pkg::BYTE_W-1:0] chr_count_reg, chr_count_next;
    logic [insl_pkg::BYTE_W-1:0] flags6_reg, flags6_next;
    logic [3:0]                  flags7_high_reg, flags7_high_next;

    logic                        m_valid_reg;
    insl_pkg::result_t           res_reg, res_next;

    logic                        accept;
    logic [insl_pkg::POS_W-1:0]  start, prg_size, chr_size, q, q_chr, len, need;
    logic [insl_pkg::POS_W-1:0]  start_next, prg_size_next, chr_size_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        start    = insl_pkg::POS_W'(insl_pkg::HEADER_LEN)
                 + (flags6_reg[insl_pkg::FLAG6_TRAINER]
                    ? insl_pkg::POS_W'(insl_pkg::TRAINER_LEN) : '0);
        prg_size = insl_pkg::POS_W'(prg_count_reg)
                 * insl_pkg::POS_W'(insl_pkg::PRG_BANK_BYTES);
        chr_size = insl_pkg::POS_W'(chr_count_reg)
                 * insl_pkg::POS_W'(insl_pkg::CHR_BANK_BYTES);
        q        = pos_reg - start;
        q_chr    = q - prg_size;

        magic_good_next  = magic_good_reg;
        prg_count_next   = prg_count_reg;
        chr_count_next   = chr_count_reg;
        flags6_next      = flags6_reg;
        flags7_high_next = flags7_high_reg;

        res_next = '0;
        res_next.load_status = insl_pkg::STATUS_OK;
        res_next.mirroring   = insl_pkg::MIRROR_HORIZONTAL;

        if (pos_reg < insl_pkg::POS_W'(insl_pkg::MAGIC_LEN)) begin
            if (s_file_byte != insl_pkg::magic_byte(pos_reg[1:0])) begin
                magic_good_next = 1'b0;
            end
        end else if (pos_reg == insl_pkg::POS_PRG_COUNT) begin
            prg_count_next = s_file_byte;
        end else if (pos_reg == insl_pkg::POS_CHR_COUNT) begin
            chr_count_next = s_file_byte;
        end else if (pos_reg == insl_pkg::POS_FLAGS6) begin
            flags6_next = s_file_byte;
        end else if (pos_reg == insl_pkg::POS_FLAGS7) begin
            flags7_high_next = s_file_byte[7:4];
        end else if (pos_reg >= insl_pkg::POS_W'(insl_pkg::HEADER_LEN) && magic_good_reg
                     && pos_reg >= start) begin
            if (q < prg_size) begin
                res_next.prg_write  = 1'b1;
                res_next.rom_offset = q[insl_pkg::OFFSET_W-1:0];
                res_next.rom_byte   = s_file_byte;
            end else if (q_chr < chr_size) begin
                res_next.chr_write  = 1'b1;
                res_next.rom_offset = q_chr[insl_pkg::OFFSET_W-1:0];
                res_next.rom_byte   = s_file_byte;
            end
        end

        len = (pos_reg == insl_pkg::POS_MAX) ? pos_reg : pos_reg + 1'b1;

        // status uses the header values as they stand after this byte
        start_next    = insl_pkg::POS_W'(insl_pkg::HEADER_LEN)
                      + (flags6_next[insl_pkg::FLAG6_TRAINER]
                         ? insl_pkg::POS_W'(insl_pkg::TRAINER_LEN) : '0);
        prg_size_next = insl_pkg::POS_W'(prg_count_next)
                      * insl_pkg::POS_W'(insl_pkg::PRG_BANK_BYTES);
        chr_size_next = insl_pkg::POS_W'(chr_count_next)
                      * insl_pkg::POS_W'(insl_pkg::CHR_BANK_BYTES);
        need          = start_next + prg_size_next + chr_size_next;

        if (s_end_of_file) begin
            res_next.image_done = 1'b1;
            if (len < insl_pkg::POS_W'(insl_pkg::HEADER_LEN)) begin
                res_next.load_status = insl_pkg::STATUS_TRUNCATED;
            end else if (!magic_good_next) begin
                res_next.load_status = insl_pkg::STATUS_BAD_MAGIC;
            end else begin
                res_next.load_status = (len < need) ? insl_pkg::STATUS_TRUNCATED
                                                    : insl_pkg::STATUS_OK;
                res_next.mapper_number = {flags7_high_next, flags6_next[7:4]};
                if (flags6_next[insl_pkg::FLAG6_FOUR_SCREEN]) begin
                    res_next.mirroring = insl_pkg::MIRROR_FOUR_SCREEN;
                end else if (flags6_next[insl_pkg::FLAG6_VERTICAL]) begin
                    res_next.mirroring = insl_pkg::MIRROR_VERTICAL;
                end else begin
                    res_next.mirroring = insl_pkg::MIRROR_HORIZONTAL;
                end
                res_next.prg_bank_count = prg_count_next;
                res_next.chr_bank_count = chr_count_next;
                res_next.chr_is_ram     = (chr_count_next == '0);
            end
            // next beat starts a fresh image
            pos_next         = '0;
            magic_good_next  = 1'b1;
            prg_count_next   = '0;
            chr_count_next   = '0;
            flags6_next      = '0;
            flags7_high_next = '0;
        end else begin
            pos_next = len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            magic_good_reg  <= 1'b1;
            prg_count_reg   <= '0;
            chr_count_reg   <= '0;
            flags6_reg      <= '0;
            flags7_high_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                pos_reg         <= pos_next;
                magic_good_reg  <= magic_good_next;
                prg_count_reg   <= prg_count_next;
                chr_count_reg   <= chr_count_next;
                flags6_reg      <= flags6_next;
                flags7_high_reg <= flags7_high_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_prg_write      = res_reg.prg_write;
    assign m_chr_write      = res_reg.chr_write;
    assign m_rom_offset     = res_reg.rom_offset;
    assign m_rom_byte       = res_reg.rom_byte;
    assign m_image_done     = res_reg.image_done;
    assign m_load_status    = res_reg.load_status;
    assign m_mapper_number  = res_reg.mapper_number;
    assign m_mirroring      = res_reg.mirroring;
    assign m_prg_bank_count = res_reg.prg_bank_count;
    assign m_chr_bank_count = res_reg.chr_bank_count;
    assign m_chr_is_ram     = res_reg.chr_is_ram;

    // a byte can never go to both roms
    a_one_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_prg_write && m_chr_write))
        else $error("prg and chr write in the same beat");

    // a non-ok status only shows on the final beat of an image
    a_status_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_load_status != insl_pkg::STATUS_OK) |-> m_image_done)
        else $error("status reported without image_done");

    // end of file rewinds the position for the next image
    a_eof_rewind: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_file) |=> (pos_reg == '0 && magic_good_reg))
        else $error("state not rewound after end of file");

    // every accepted beat leaves a result in the output register
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted beat produced no result");

endmodule

`default_nettype wire

### tb/tb_ines_image_stream_loader_core.sv
// tb_ines_image_stream_loader_core: self-checking bench for the ROM image stream loader core
// drives byte beats with random gaps, predicts or is given every result beat and compares field by field
// depends on insl_pkg and ines_image_stream_loader_core
`timescale 1ns / 100ps

module tb_ines_image_stream_loader_core;

    localparam int RANDOM_ITEMS   = 1100;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [7:0] MAGIC [4] = '{8'h4e, 8'h45, 8'h53, 8'h1a};

    typedef enum int {
        IMG_SHORT,
        IMG_BAD_MAGIC,
        IMG_NO_BODY,
        IMG_CUT_PRG,
        IMG_CUT_CHR,
        IMG_CUT_TRAINER,
        IMG_PAST_TRAINER,
        IMG_COMPLETE
    } image_kind_t;

    typedef struct {
        logic [7:0]         data;
        logic               last;
        bit                 typed;
        insl_pkg::result_t  want;
    } stim_row_t;

    logic                          aclk;
    logic                          aresetn       = 1'b0;
    logic                          s_valid       = 1'b0;
    logic [insl_pkg::BYTE_W-1:0]   s_file_byte   = '0;
    logic                          s_end_of_file = 1'b0;
    logic                          m_ready       = 1'b0;
    logic                          s_ready;
    logic                          m_valid;
    logic                          m_prg_write;
    logic                          m_chr_write;
    logic [insl_pkg::OFFSET_W-1:0] m_rom_offset;
    logic [insl_pkg::BYTE_W-1:0]   m_rom_byte;
    logic                          m_image_done;
    logic [1:0]                    m_load_status;
    logic [insl_pkg::BYTE_W-1:0]   m_mapper_number;
    logic [1:0]                    m_mirroring;
    logic [insl_pkg::BYTE_W-1:0]   m_prg_bank_count;
    logic [insl_pkg::BYTE_W-1:0]   m_chr_bank_count;
    logic                          m_chr_is_ram;

    insl_pkg::result_t rom_results_due[$];
    stim_row_t         directed_rows[$];
    insl_pkg::result_t seen_beat;
    int                fault_count  = 0;
    int                beats_seen   = 0;
    int                quiet_cycles = 0;
    int                ready_hold   = 0;
    int                ready_roll;
    bit                sender_gaps  = 1'b1;

    // predictor copy of the parser state
    logic [insl_pkg::POS_W-1:0] ld_pos;
    logic                       ld_magic_ok;
    logic [7:0]                 ld_prg_banks;
    logic [7:0]                 ld_chr_banks;
    logic [7:0]                 ld_flags6;
    logic [3:0]                 ld_flags7_hi;

    ines_image_stream_loader_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_file_byte      (s_file_byte),
        .s_end_of_file    (s_end_of_file),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_prg_write      (m_prg_write),
        .m_chr_write      (m_chr_write),
        .m_rom_offset     (m_rom_offset),
        .m_rom_byte       (m_rom_byte),
        .m_image_done     (m_image_done),
        .m_load_status    (m_load_status),
        .m_mapper_number  (m_mapper_number),
        .m_mirroring      (m_mirroring),
        .m_prg_bank_count (m_prg_bank_count),
        .m_chr_bank_count (m_chr_bank_count),
        .m_chr_is_ram     (m_chr_is_ram)
    );

    assign seen_beat = {m_prg_write, m_chr_write, m_rom_offset, m_rom_byte, m_image_done,
                        m_load_status, m_mapper_number, m_mirroring, m_prg_bank_count,
                        m_chr_bank_count, m_chr_is_ram};

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic clear_image_state();
        ld_pos       = '0;
        ld_magic_ok  = 1'b1;
        ld_prg_banks = '0;
        ld_chr_banks = '0;
        ld_flags6    = '0;
        ld_flags7_hi = '0;
    endtask

    task automatic predict_rom_beat(input logic [7:0] data, input logic last,
                                    output insl_pkg::result_t r);
        int unsigned pos;
        int unsigned start;
        int unsigned prg_len;
        int unsigned chr_len;
        int unsigned q;
        r       = '0;
        pos     = 32'(ld_pos);
        start   = insl_pkg::HEADER_LEN
                + (ld_flags6[insl_pkg::FLAG6_TRAINER] ? insl_pkg::TRAINER_LEN : 0);
        prg_len = int'(ld_prg_banks) * insl_pkg::PRG_BANK_BYTES;
        chr_len = int'(ld_chr_banks) * insl_pkg::CHR_BANK_BYTES;
        if (pos < insl_pkg::MAGIC_LEN) begin
            if (data != MAGIC[pos[1:0]]) ld_magic_ok = 1'b0;
        end else if (pos == insl_pkg::POS_PRG_COUNT) begin
            ld_prg_banks = data;
        end else if (pos == insl_pkg::POS_CHR_COUNT) begin
            ld_chr_banks = data;
        end else if (pos == insl_pkg::POS_FLAGS6) begin
            ld_flags6 = data;
        end else if (pos == insl_pkg::POS_FLAGS7) begin
            ld_flags7_hi = data[7:4];
        end else if (pos >= insl_pkg::HEADER_LEN && ld_magic_ok && pos >= start) begin
            q = pos - start;
            if (q < prg_len) begin
                r.prg_write  = 1'b1;
                r.rom_offset = insl_pkg::OFFSET_W'(q);
                r.rom_byte   = data;
            end else if (q - prg_len < chr_len) begin
                r.chr_write  = 1'b1;
                r.rom_offset = insl_pkg::OFFSET_W'(q - prg_len);
                r.rom_byte   = data;
            end
        end
        if (ld_pos != insl_pkg::POS_MAX) ld_pos = ld_pos + 1'b1;
        if (last) begin
            r.image_done = 1'b1;
            // short header wins over bad magic
            if (ld_pos < insl_pkg::HEADER_LEN) begin
                r.load_status = insl_pkg::STATUS_TRUNCATED;
            end else if (!ld_magic_ok) begin
                r.load_status = insl_pkg::STATUS_BAD_MAGIC;
            end else begin
                r.load_status    = (ld_pos < start + prg_len + chr_len)
                                 ? insl_pkg::STATUS_TRUNCATED : insl_pkg::STATUS_OK;
                r.mapper_number  = {ld_flags7_hi, ld_flags6[7:4]};
                r.mirroring      = ld_flags6[insl_pkg::FLAG6_FOUR_SCREEN]
                                 ? insl_pkg::MIRROR_FOUR_SCREEN :
                                   ld_flags6[insl_pkg::FLAG6_VERTICAL]
                                 ? insl_pkg::MIRROR_VERTICAL : insl_pkg::MIRROR_HORIZONTAL;
                r.prg_bank_count = ld_prg_banks;
                r.chr_bank_count = ld_chr_banks;
                r.chr_is_ram     = (ld_chr_banks == 8'd0);
            end
            clear_image_state();
        end
    endtask

    task automatic report_field(input string field, input logic [31:0] got,
                                input logic [31:0] want);
        $display("beat %0d: %s got 0x%0h want 0x%0h", beats_seen, field, got, want);
        fault_count++;
    endtask

    task automatic check_rom_beat(input insl_pkg::result_t got);
        insl_pkg::result_t want;
        if (rom_results_due.size() == 0) begin
            report_field("beat with nothing expected", 32'(got.image_done), 32'd0);
        end else begin
            want = rom_results_due.pop_front();
            if (got.prg_write !== want.prg_write)
                report_field("prg_write", 32'(got.prg_write), 32'(want.prg_write));
            if (got.chr_write !== want.chr_write)
                report_field("chr_write", 32'(got.chr_write), 32'(want.chr_write));
            if (got.rom_offset !== want.rom_offset)
                report_field("rom_offset", 32'(got.rom_offset), 32'(want.rom_offset));
            if (got.rom_byte !== want.rom_byte)
                report_field("rom_byte", 32'(got.rom_byte), 32'(want.rom_byte));
            if (got.image_done !== want.image_done)
                report_field("image_done", 32'(got.image_done), 32'(want.image_done));
            if (got.load_status !== want.load_status)
                report_field("load_status", 32'(got.load_status), 32'(want.load_status));
            if (got.mapper_number !== want.mapper_number)
                report_field("mapper_number", 32'(got.mapper_number),
                             32'(want.mapper_number));
            if (got.mirroring !== want.mirroring)
                report_field("mirroring", 32'(got.mirroring), 32'(want.mirroring));
            if (got.prg_bank_count !== want.prg_bank_count)
                report_field("prg_bank_count", 32'(got.prg_bank_count),
                             32'(want.prg_bank_count));
            if (got.chr_bank_count !== want.chr_bank_count)
                report_field("chr_bank_count", 32'(got.chr_bank_count),
                             32'(want.chr_bank_count));
            if (got.chr_is_ram !== want.chr_is_ram)
                report_field("chr_is_ram", 32'(got.chr_is_ram), 32'(want.chr_is_ram));
        end
        beats_seen++;
    endtask

    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic last, input bit typed,
                             input insl_pkg::result_t want);
        int                gap;
        insl_pkg::result_t predicted;
        gap = sender_gaps ? gap_cycles() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_file_byte   <= data;
        s_end_of_file <= last;
        do @(posedge aclk); while (!s_ready);
        predict_rom_beat(data, last, predicted);
        rom_results_due.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (rom_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic add_row(input logic [7:0] data, input logic last, input bit typed,
                           input insl_pkg::result_t want);
        stim_row_t row;
        row.data  = data;
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_image(input image_kind_t kind, output int sent);
        logic [7:0] hdr [insl_pkg::HEADER_LEN];
        int         total;
        int         cut;
        foreach (hdr[i]) hdr[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < insl_pkg::MAGIC_LEN; i++) hdr[i] = MAGIC[i];
        hdr[insl_pkg::POS_FLAGS6][insl_pkg::FLAG6_TRAINER] = 1'b0;
        total = insl_pkg::HEADER_LEN + $urandom_range(0, 60);
        case (kind)
            IMG_SHORT: begin
                total = $urandom_range(1, insl_pkg::HEADER_LEN - 1);
                if ($urandom_range(0, 1) == 1) begin
                    cut      = $urandom_range(0, insl_pkg::MAGIC_LEN - 1);
                    hdr[cut] = hdr[cut] ^ 8'($urandom_range(1, 255));
                end
            end
            IMG_BAD_MAGIC: begin
                cut      = $urandom_range(0, insl_pkg::MAGIC_LEN - 1);
                hdr[cut] = hdr[cut] ^ 8'($urandom_range(1, 255));
                hdr[insl_pkg::POS_FLAGS6][insl_pkg::FLAG6_TRAINER] = 1'($urandom_range(0, 1));
                total    = insl_pkg::HEADER_LEN + $urandom_range(0, 24);
            end
            IMG_NO_BODY: begin
                hdr[insl_pkg::POS_PRG_COUNT] = 8'd0;
                hdr[insl_pkg::POS_CHR_COUNT] = 8'd0;
                // everything past the header is surplus
                total = insl_pkg::HEADER_LEN + $urandom_range(0, 20);
            end
            IMG_CUT_PRG: begin
                hdr[insl_pkg::POS_PRG_COUNT] = ($urandom_range(0, 7) == 0)
                                             ? 8'hff : 8'($urandom_range(1, 3));
            end
            IMG_CUT_CHR: begin
                hdr[insl_pkg::POS_PRG_COUNT] = 8'd0;
                hdr[insl_pkg::POS_CHR_COUNT] = ($urandom_range(0, 7) == 0)
                                             ? 8'hff : 8'($urandom_range(1, 3));
            end
            IMG_CUT_TRAINER: begin
                hdr[insl_pkg::POS_FLAGS6][insl_pkg::FLAG6_TRAINER] = 1'b1;
            end
            IMG_PAST_TRAINER: begin
                hdr[insl_pkg::POS_FLAGS6][insl_pkg::FLAG6_TRAINER] = 1'b1;
                hdr[insl_pkg::POS_PRG_COUNT] = 8'd1;
                total = insl_pkg::HEADER_LEN + insl_pkg::TRAINER_LEN + $urandom_range(1, 40);
            end
            IMG_COMPLETE: begin
                // trainer skipped, no banks, then a few surplus bytes
                hdr[insl_pkg::POS_FLAGS6][insl_pkg::FLAG6_TRAINER] = 1'b1;
                hdr[insl_pkg::POS_PRG_COUNT] = 8'd0;
                hdr[insl_pkg::POS_CHR_COUNT] = 8'd0;
                total = insl_pkg::HEADER_LEN + insl_pkg::TRAINER_LEN + $urandom_range(0, 8);
            end
            default: ;
        endcase
        sender_gaps = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < total; i++)
            send_byte(i < insl_pkg::HEADER_LEN ? hdr[i] : 8'($urandom_range(0, 255)),
                      i == total - 1, 1'b0, '0);
        sent = total;
    endtask

    // result side back-pressure: mostly ready, short and long stalls
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 70) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 24);
            end else if (ready_roll < 95) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(10, 60);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_rom_beat(seen_beat);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("ines_image_stream_loader_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        insl_pkg::result_t w;
        int                random_items;
        int                image_idx;
        int                sent;
        int                roll;
        image_kind_t       kind;

        clear_image_state();

        // lone byte with end of file: short header even though magic is also wrong
        w             = '0;
        w.image_done  = 1'b1;
        w.load_status = insl_pkg::STATUS_TRUNCATED;
        add_row(8'h00, 1'b1, 1'b1, w);
        // header: one prg bank, no chr, four-screen with vertical bit set, mapper 0xff
        for (int i = 0; i < insl_pkg::MAGIC_LEN; i++) add_row(MAGIC[i], 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0);
        add_row(8'hf9, 1'b0, 1'b0, '0);
        add_row(8'hff, 1'b0, 1'b0, '0);
        for (int i = 8; i < insl_pkg::HEADER_LEN; i++)
            add_row(i[0] ? 8'hff : 8'h00, 1'b0, 1'b0, '0);
        // three prg bytes, then the image stops short
        w            = '0;
        w.prg_write  = 1'b1;
        w.rom_byte   = 8'h00;
        add_row(8'h00, 1'b0, 1'b1, w);
        w.rom_offset = 22'd1;
        w.rom_byte   = 8'hff;
        add_row(8'hff, 1'b0, 1'b1, w);
        w.rom_offset     = 22'd2;
        w.rom_byte       = 8'h5a;
        w.image_done     = 1'b1;
        w.load_status    = insl_pkg::STATUS_TRUNCATED;
        w.mapper_number  = 8'hff;
        w.mirroring      = insl_pkg::MIRROR_FOUR_SCREEN;
        w.prg_bank_count = 8'd1;
        w.chr_bank_count = 8'd0;
        w.chr_is_ram     = 1'b1;
        add_row(8'h5a, 1'b1, 1'b1, w);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k])
            send_byte(directed_rows[k].data, directed_rows[k].last, directed_rows[k].typed,
                      directed_rows[k].want);

        random_items = 0;
        image_idx    = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (image_idx == 5 || $urandom_range(0, 7) == 0) wait_drained();
            if (image_idx == 3) begin
                send_image(IMG_COMPLETE, sent);
            end else if (image_idx == 6) begin
                send_image(IMG_PAST_TRAINER, sent);
            end else begin
                roll = $urandom_range(0, 99);
                kind = (roll < 10) ? IMG_SHORT :
                       (roll < 25) ? IMG_BAD_MAGIC :
                       (roll < 40) ? IMG_NO_BODY :
                       (roll < 65) ? IMG_CUT_PRG :
                       (roll < 85) ? IMG_CUT_CHR : IMG_CUT_TRAINER;
                send_image(kind, sent);
            end
            random_items += sent;
            image_idx++;
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (rom_results_due.size() != 0)
            report_field("beats never delivered", rom_results_due.size(), 32'd0);
        if (fault_count == 0) begin
            $display("ines_image_stream_loader_core: match");
        end else begin
            $display("ines_image_stream_loader_core: mismatch");
        end
        $finish;
    end

endmodule
